// ===== design/c2d_mac_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_mac_pkg
// Shared types, codes and helpers for the 2D convolution MAC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_mac_pkg;

    localparam int unsigned OUT_W   = 40;
    localparam int unsigned CFG_IW  = 3;
    localparam int unsigned CFG_DW  = 6;

    typedef enum logic [1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_IN_CH  = 3'd0,
        REG_OUT_CH = 3'd1,
        REG_K_ROWS = 3'd2,
        REG_K_COLS = 3'd3,
        REG_I_ROWS = 3'd4,
        REG_I_COLS = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // zero acts as one, anything above the bound acts as the bound
    function automatic logic [CFG_DW-1:0] eff_val(input logic [CFG_DW-1:0] v,
                                                   input int unsigned hi);
        logic [CFG_DW-1:0] r;
        if (v == '0) begin
            r = CFG_DW'(1);
        end else if (32'(v) > hi) begin
            r = CFG_DW'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/conv2d_valid_mac_engine_top.sv =====
// ----------------------------------------------------------------------------
// conv2d_valid_mac_engine_top
// Multichannel 2D valid convolution with weight/sample stores and one MAC.
// ----------------------------------------------------------------------------
// Weight and sample write beats are accepted back to back while idle.
// A compute beat walks all in_channels * kernel_rows * kernel_cols taps, then
// drains and registers its result; one shared MAC consumes one tap per cycle.
// An out-of-range compute skips the MAC run and goes straight to the output state.
// A result beat held by m_tready holds off only the next result; input beats are still taken while idle.
// aresetn is synchronous, active low; store contents are not cleared.
`default_nettype none

module conv2d_valid_mac_engine_top
    import c2d_mac_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_KERNEL   = 8,
    parameter int MAX_DIM      = 32,
    parameter int DATA_WIDTH   = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // out_chan[2:0], in_chan[5:3], row[10:6], col[15:11], value[31:16]
    input  wire logic [31:0]       s_tdata,
    // kind[1:0]
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // out_value[39:0], res_chan[42:40], res_row[47:43], res_col[52:48], zero pad
    output logic [55:0]            m_tdata,
    // status[0]
    output logic                   m_tuser
);

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int RW    = $clog2(MAX_DIM);
    localparam int PW    = (RW > 6) ? RW + 1 : 7;
    localparam int WAW   = 2 * CW + 2 * KW;
    localparam int SAW   = CW + 2 * RW;
    localparam int ACC_W = (2 * DATA_WIDTH + 12 > OUT_W + 1) ? 2 * DATA_WIDTH + 12 : OUT_W + 1;

    // input fields
    logic [1:0]         in_kind;
    logic [2:0]         in_oc;
    logic [2:0]         in_ic;
    logic [4:0]         in_row;
    logic [4:0]         in_col;
    logic signed [15:0] in_value;
    logic signed [DATA_WIDTH-1:0] store_val;

    assign in_kind  = s_tuser;
    assign in_oc    = s_tdata[2:0];
    assign in_ic    = s_tdata[5:3];
    assign in_row   = s_tdata[10:6];
    assign in_col   = s_tdata[15:11];
    assign in_value = s_tdata[31:16];
    assign store_val = DATA_WIDTH'(in_value);

    // configuration
    logic [3:0] in_ch_reg, out_ch_reg, k_rows_reg, k_cols_reg;
    logic [5:0] i_rows_reg, i_cols_reg;
    logic [3:0] eff_ic, eff_oc, eff_kr, eff_kc;
    logic [5:0] eff_ir, eff_icl;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= 4'd1;
            out_ch_reg <= 4'd1;
            k_rows_reg <= 4'd3;
            k_cols_reg <= 4'd3;
            i_rows_reg <= 6'd32;
            i_cols_reg <= 6'd32;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IN_CH:  in_ch_reg  <= cfg_data[3:0];
                REG_OUT_CH: out_ch_reg <= cfg_data[3:0];
                REG_K_ROWS: k_rows_reg <= cfg_data[3:0];
                REG_K_COLS: k_cols_reg <= cfg_data[3:0];
                REG_I_ROWS: i_rows_reg <= cfg_data;
                REG_I_COLS: i_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [5:0] eff_ic6, eff_oc6, eff_kr6, eff_kc6;
    assign eff_ic6 = eff_val({2'b00, in_ch_reg}, MAX_CHANNELS);
    assign eff_oc6 = eff_val({2'b00, out_ch_reg}, MAX_CHANNELS);
    assign eff_kr6 = eff_val({2'b00, k_rows_reg}, MAX_KERNEL);
    assign eff_kc6 = eff_val({2'b00, k_cols_reg}, MAX_KERNEL);
    assign eff_ic  = eff_ic6[3:0];
    assign eff_oc  = eff_oc6[3:0];
    assign eff_kr  = eff_kr6[3:0];
    assign eff_kc  = eff_kc6[3:0];
    assign eff_ir  = eff_val(i_rows_reg, MAX_DIM);
    assign eff_icl = eff_val(i_cols_reg, MAX_DIM);

    // sequencer
    state_t     state_reg, state_next;
    logic       s_acc;
    logic       bad;
    logic [2:0] oc_reg;
    logic [4:0] row_reg, col_reg;
    logic       bad_reg;
    logic [3:0] ic_cnt_reg, ic_cnt_next;
    logic [3:0] n_cnt_reg, n_cnt_next;
    logic [3:0] k_cnt_reg, k_cnt_next;
    logic       rd_vld_reg, rd_vld_next;
    logic       mul_vld_reg, mul_vld_next;
    logic       k_last, n_last, ic_last;
    logic       out_free;
    logic       out_load;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign bad      = ({1'b0, in_oc} >= eff_oc)
                   || (7'(in_row) + 7'(eff_kr) > 7'(eff_ir))
                   || (7'(in_col) + 7'(eff_kc) > 7'(eff_icl));

    assign k_last   = (k_cnt_reg == eff_kc - 4'd1);
    assign n_last   = (n_cnt_reg == eff_kr - 4'd1);
    assign ic_last  = (ic_cnt_reg == eff_ic - 4'd1);
    assign out_free = !m_tvalid || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_comb begin
        state_next   = state_reg;
        ic_cnt_next  = ic_cnt_reg;
        n_cnt_next   = n_cnt_reg;
        k_cnt_next   = k_cnt_reg;
        rd_vld_next  = 1'b0;
        mul_vld_next = rd_vld_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && in_kind == KIND_COMPUTE) begin
                    ic_cnt_next = '0;
                    n_cnt_next  = '0;
                    k_cnt_next  = '0;
                    state_next  = bad ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                rd_vld_next = 1'b1;
                if (!k_last) begin
                    k_cnt_next = k_cnt_reg + 4'd1;
                end else begin
                    k_cnt_next = '0;
                    if (!n_last) begin
                        n_cnt_next = n_cnt_reg + 4'd1;
                    end else begin
                        n_cnt_next  = '0;
                        ic_cnt_next = ic_cnt_reg + 4'd1;
                        if (ic_last) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ic_cnt_reg  <= '0;
            n_cnt_reg   <= '0;
            k_cnt_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ic_cnt_reg  <= ic_cnt_next;
            n_cnt_reg   <= n_cnt_next;
            k_cnt_reg   <= k_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= mul_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_kind == KIND_COMPUTE) begin
            oc_reg  <= in_oc;
            row_reg <= in_row;
            col_reg <= in_col;
            bad_reg <= bad;
        end
    end

    // stores
    logic signed [DATA_WIDTH-1:0] weight_mem [2**WAW];
    logic signed [DATA_WIDTH-1:0] sample_mem [2**SAW];
    logic signed [DATA_WIDTH-1:0] weight_rd_reg, sample_rd_reg;
    logic           w_we, s_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [PW-1:0]  row_sum, col_sum;

    assign w_we = s_acc && in_kind == KIND_WEIGHT
               && 32'(in_oc) < MAX_CHANNELS && 32'(in_ic) < MAX_CHANNELS
               && 32'(in_row) < MAX_KERNEL && 32'(in_col) < MAX_KERNEL;
    assign s_we = s_acc && in_kind == KIND_SAMPLE
               && 32'(in_ic) < MAX_CHANNELS
               && 32'(in_row) < MAX_DIM && 32'(in_col) < MAX_DIM;

    assign w_waddr = {CW'(in_oc), CW'(in_ic), KW'(in_row), KW'(in_col)};
    assign s_waddr = {CW'(in_ic), RW'(in_row), RW'(in_col)};

    assign row_sum = PW'(row_reg) + PW'(n_cnt_reg);
    assign col_sum = PW'(col_reg) + PW'(k_cnt_reg);
    assign w_raddr = {CW'(oc_reg), CW'(ic_cnt_reg), KW'(n_cnt_reg), KW'(k_cnt_reg)};
    assign s_raddr = {CW'(ic_cnt_reg), RW'(row_sum), RW'(col_sum)};

    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_waddr] <= store_val;
        end
        weight_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            sample_mem[s_waddr] <= store_val;
        end
        sample_rd_reg <= sample_mem[s_raddr];
    end

    // multiply-accumulate
    logic signed [2*DATA_WIDTH-1:0] product_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    always_ff @(posedge aclk) begin
        product_reg <= sample_rd_reg * weight_rd_reg;
        if (s_acc && in_kind == KIND_COMPUTE) begin
            acc_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(product_reg);
        end
    end

    // saturation to the result width
    logic [ACC_W-OUT_W:0] acc_top;
    logic                 in_range;
    logic [OUT_W-1:0]     sat_val;

    assign acc_top  = acc_reg[ACC_W-1:OUT_W-1];
    assign in_range = (acc_top == '0) || (acc_top == '1);
    assign sat_val  = in_range ? acc_reg[OUT_W-1:0]
                    : (acc_reg[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                        : {1'b0, {(OUT_W-1){1'b1}}});

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_value_reg;
    logic             m_status_reg;
    logic [2:0]       m_chan_reg;
    logic [4:0]       m_row_reg, m_col_reg;

    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg  <= bad_reg ? '0 : sat_val;
            m_status_reg <= bad_reg;
            m_chan_reg   <= oc_reg;
            m_row_reg    <= row_reg;
            m_col_reg    <= col_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_col_reg, m_row_reg, m_chan_reg, m_value_reg};

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_W-1:0] == '0)
        else $error("out-of-range result carries a nonzero value");

    a_mul_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_vld_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("product valid outside a compute run");

    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> (k_cnt_reg < eff_kc && n_cnt_reg < eff_kr
                                 && ic_cnt_reg < eff_ic))
        else $error("tap counter beyond kernel bounds");
`endif

endmodule

`default_nettype wire
